// File: hw/rtl/kpdc_pkg.sv
// Package for the key press duration classifier.
// Holds widths, register indexes, reset values and the event codes.
// Depends on nothing; every other file of the block uses it.
package kpdc_pkg;

   // Width of the held tick counter by default.
   localparam int COUNT_BITS_DEFAULT = 10;

   // Widths of the fixed fields.
   localparam int TICK_W    = 10;
   localparam int EVENT_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 10;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_HOLD_TICKS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_HOLD_TICKS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICK_ENABLE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_ENABLE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_ENABLE     = 3'd5;

   // Register values after reset.
   localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RESET   = 10'd3;
   localparam logic [TICK_W-1:0] PAIR_HOLD_TICKS_RESET  = 10'd200;
   localparam logic [TICK_W-1:0] RESET_HOLD_TICKS_RESET = 10'd500;

   // Classes reported on release.
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE  = 2'd0,
      EV_CLICK = 2'd1,
      EV_PAIR  = 2'd2,
      EV_RESET = 2'd3
   } key_event_type;

endpackage

// File: hw/rtl/kpdc_if.sv
// Channel interfaces of the key press duration classifier.
// Sample input, event output and register write channel; uses kpdc_pkg.
interface kpdc_req_if;
   logic valid;
   logic ready;
   logic key_low;

   modport source (output valid, output key_low, input ready);
   modport sink   (input valid, input key_low, output ready);
endinterface

interface kpdc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kpdc_pkg::EVENT_W-1:0]  key_event;

   modport source (output valid, output key_event, input ready);
   modport sink   (input valid, input key_event, output ready);
endinterface

interface kpdc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [kpdc_pkg::CSR_IDX_W-1:0]  index;
   logic [kpdc_pkg::CSR_DAT_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/key_press_duration_classifier_unit.sv
// Top level of the key press duration classifier.
// Depends on kpdc_pkg and the channel interfaces in kpdc_if.sv.
//
//   channel  | direction | payload                        | handshake
//   ---------+-----------+--------------------------------+-------------
//   req_ch   | in        | key_low (1 bit)                | valid/ready
//   rsp_ch   | out       | key_event (2 bit)              | valid/ready
//   csr_ch   | in        | index (3 bit), data (10 bit)   | valid/ready
//
// Every accepted sample word produces exactly one event word in the output register.
// A new sample word can be taken every cycle; the only limit is the single
// output register, which must be empty or draining in the same cycle.
// Reset is synchronous and active high; it restores the register defaults.
// Register writes are always accepted and take effect on the next cycle.
module key_press_duration_classifier_unit #(
   parameter int COUNT_BITS = kpdc_pkg::COUNT_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   kpdc_req_if.sink   req_ch,
   kpdc_rsp_if.source rsp_ch,
   kpdc_csr_if.sink   csr_ch
);

   // The held counter and the thresholds are compared at a common width.
   localparam int CMP_W = (COUNT_BITS > kpdc_pkg::TICK_W) ? COUNT_BITS : kpdc_pkg::TICK_W;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_HOLD = 2'd2
   } phase_type;

   // Configuration registers.
   logic [kpdc_pkg::TICK_W-1:0] debounce_ticks_ff;
   logic [kpdc_pkg::TICK_W-1:0] pair_hold_ticks_ff;
   logic [kpdc_pkg::TICK_W-1:0] reset_hold_ticks_ff;
   logic                        click_enable_ff;
   logic                        pair_enable_ff;
   logic                        reset_enable_ff;

   // Classifier state and its next values.
   phase_type                   phase_ff, phase_in;
   logic                        last_level_low_ff, last_level_low_in;
   logic [kpdc_pkg::TICK_W-1:0] wait_count_ff, wait_count_in;
   logic [COUNT_BITS-1:0]       held_count_ff, held_count_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   kpdc_pkg::key_event_type     rsp_event_ff, rsp_event_in;

   logic                        req_accept;
   logic                        wait_step_done;
   logic [kpdc_pkg::TICK_W-1:0] wait_count_inc;
   logic [CMP_W-1:0]            held_wide;
   logic [CMP_W-1:0]            pair_wide;
   logic [CMP_W-1:0]            reset_wide;
   kpdc_pkg::key_event_type     release_event;

   // The output register can take a new word when it is empty or being drained.
   assign req_ch.ready     = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.key_event = rsp_event_ff;

   // Release classification: longest threshold first, disabled classes fall through.
   assign held_wide  = CMP_W'(held_count_ff);
   assign pair_wide  = CMP_W'(pair_hold_ticks_ff);
   assign reset_wide = CMP_W'(reset_hold_ticks_ff);

   always_comb begin
      if (reset_enable_ff && (held_wide >= reset_wide)) begin
         release_event = kpdc_pkg::EV_RESET;
      end else if (pair_enable_ff && (held_wide >= pair_wide)) begin
         release_event = kpdc_pkg::EV_PAIR;
      end else if (click_enable_ff) begin
         release_event = kpdc_pkg::EV_CLICK;
      end else begin
         release_event = kpdc_pkg::EV_NONE;
      end
   end

   // The debounce counter saturates; a threshold of zero is met on the first
   // tick after the edge, exactly as a threshold of one.
   assign wait_count_inc = (wait_count_ff != '1) ? (wait_count_ff + 1'b1) : wait_count_ff;
   assign wait_step_done = (wait_count_inc >= debounce_ticks_ff);

   always_comb begin
      phase_in          = phase_ff;
      last_level_low_in = last_level_low_ff;
      wait_count_in     = wait_count_ff;
      held_count_in     = held_count_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_event_in      = rsp_event_ff;

      if (req_accept) begin
         last_level_low_in = req_ch.key_low;
         rsp_valid_in      = 1'b1;
         rsp_event_in      = kpdc_pkg::EV_NONE;

         unique case (phase_ff)
            PH_WAIT: begin
               wait_count_in = wait_count_inc;
               if (wait_step_done) begin
                  wait_count_in = '0;
                  if (req_ch.key_low) begin
                     phase_in      = PH_HOLD;
                     held_count_in = COUNT_BITS'(1);
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_HOLD: begin
               if (req_ch.key_low) begin
                  if (held_count_ff != '1) begin
                     held_count_in = held_count_ff + 1'b1;
                  end
               end else begin
                  rsp_event_in  = release_event;
                  held_count_in = '0;
                  phase_in      = PH_IDLE;
               end
            end
            default: begin
               // Idle: a fresh press edge starts the debounce wait.
               phase_in = PH_IDLE;
               if (req_ch.key_low && !last_level_low_ff) begin
                  phase_in      = PH_WAIT;
                  wait_count_in = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff   <= kpdc_pkg::DEBOUNCE_TICKS_RESET;
         pair_hold_ticks_ff  <= kpdc_pkg::PAIR_HOLD_TICKS_RESET;
         reset_hold_ticks_ff <= kpdc_pkg::RESET_HOLD_TICKS_RESET;
         click_enable_ff     <= 1'b0;
         pair_enable_ff      <= 1'b0;
         reset_enable_ff     <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            kpdc_pkg::CSR_DEBOUNCE_TICKS:   debounce_ticks_ff   <= csr_ch.data;
            kpdc_pkg::CSR_PAIR_HOLD_TICKS:  pair_hold_ticks_ff  <= csr_ch.data;
            kpdc_pkg::CSR_RESET_HOLD_TICKS: reset_hold_ticks_ff <= csr_ch.data;
            kpdc_pkg::CSR_CLICK_ENABLE:     click_enable_ff     <= csr_ch.data[0];
            kpdc_pkg::CSR_PAIR_ENABLE:      pair_enable_ff      <= csr_ch.data[0];
            kpdc_pkg::CSR_RESET_ENABLE:     reset_enable_ff     <= csr_ch.data[0];
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         last_level_low_ff <= 1'b0;
         wait_count_ff     <= '0;
         held_count_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         last_level_low_ff <= last_level_low_in;
         wait_count_ff     <= wait_count_in;
         held_count_ff     <= held_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      rsp_event_ff <= rsp_event_in;
   end

   // The held counter is only in use while a press is being held.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HOLD) |-> (held_count_ff == '0))
      else $error("held counter nonzero outside the hold phase");

   // The debounce counter is only in use during the wait.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_WAIT) |-> (wait_count_ff == '0))
      else $error("debounce counter nonzero outside the wait phase");

   // Every accepted sample leaves a word in the output register.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted sample produced no event word");

   // Only a release during a hold can report a class.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (phase_ff != PH_HOLD)) |=> (rsp_event_ff == kpdc_pkg::EV_NONE))
      else $error("event reported outside a held press");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for key_press_duration_classifier_unit.
// Drives key samples and register writes, predicts every event word and compares it.
// Depends on kpdc_pkg and the channel interfaces in kpdc_if.sv.
module testbench;

   // Phases of the press tracker as the prediction sees them.
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_HOLD = 2'd2
   } press_phase_type;

   // Indexes that map to no register; writes there must change nothing.
   localparam logic [kpdc_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [kpdc_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int HELD_W      = kpdc_pkg::COUNT_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 100000;
   localparam int IDLE_PCT    = 29;

   logic clock = 1'b0;
   logic reset;

   kpdc_req_if req_ch ();
   kpdc_rsp_if rsp_ch ();
   kpdc_csr_if csr_ch ();

   key_press_duration_classifier_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Register copies, updated when a write word is accepted.
   logic [kpdc_pkg::TICK_W-1:0] cfg_debounce;
   logic [kpdc_pkg::TICK_W-1:0] cfg_pair_ticks;
   logic [kpdc_pkg::TICK_W-1:0] cfg_reset_ticks;
   logic                        cfg_click_en;
   logic                        cfg_pair_en;
   logic                        cfg_reset_en;

   // Predicted state of the press tracker.
   press_phase_type             press_phase;
   logic                        last_key_low;
   logic [kpdc_pkg::TICK_W-1:0] wait_ticks;
   logic [HELD_W-1:0]           held_ticks;

   // Events predicted for accepted samples, oldest first.
   kpdc_pkg::key_event_type expected_events[$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  samples_sent = 0;
   int  csr_writes = 0;
   int  event_tally[4] = '{0, 0, 0, 0};
   bit  steady_flow = 1'b0;

   always #5 clock = ~clock;

   // The run is cut off here if the block stops moving.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d events still pending",
                  cycle_count, expected_events.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // The event sink stalls at random, except during the steady stretch.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < 30) begin
         $display("[%0t] event error: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // Advances the predicted tracker by one tick and returns the event that the
   // tick reports. The longest hold class wins, and a disabled class falls
   // through to the next shorter one.
   function automatic kpdc_pkg::key_event_type predict_key_event(input logic key_low);
      kpdc_pkg::key_event_type ev;
      ev = kpdc_pkg::EV_NONE;
      case (press_phase)
         PH_WAIT: begin
            if (wait_ticks != '1) begin
               wait_ticks = wait_ticks + 1'b1;
            end
            // A debounce setting of zero behaves like one, since the count
            // has already moved past it here.
            if (wait_ticks >= cfg_debounce) begin
               if (key_low) begin
                  press_phase = PH_HOLD;
                  held_ticks  = HELD_W'(1);
               end else begin
                  press_phase = PH_IDLE;
               end
               wait_ticks = '0;
            end
         end
         PH_HOLD: begin
            if (key_low) begin
               if (held_ticks != '1) begin
                  held_ticks = held_ticks + 1'b1;
               end
            end else begin
               if (cfg_reset_en && held_ticks >= cfg_reset_ticks) begin
                  ev = kpdc_pkg::EV_RESET;
               end else if (cfg_pair_en && held_ticks >= cfg_pair_ticks) begin
                  ev = kpdc_pkg::EV_PAIR;
               end else if (cfg_click_en) begin
                  ev = kpdc_pkg::EV_CLICK;
               end
               held_ticks  = '0;
               press_phase = PH_IDLE;
            end
         end
         default: begin
            // Only a fresh falling edge of the pin starts a press; edges seen
            // during the wait or the hold fall into the branches above.
            press_phase = PH_IDLE;
            if (key_low && !last_key_low) begin
               press_phase = PH_WAIT;
               wait_ticks  = '0;
            end
         end
      endcase
      last_key_low = key_low;
      return ev;
   endfunction

   // Monitor: everything is sampled at the rising edge. The event check comes
   // before the new prediction, since an event word never leaves in the cycle
   // in which its sample word is accepted.
   always @(posedge clock) begin
      kpdc_pkg::key_event_type want;
      if (reset) begin
         cfg_debounce    = kpdc_pkg::DEBOUNCE_TICKS_RESET;
         cfg_pair_ticks  = kpdc_pkg::PAIR_HOLD_TICKS_RESET;
         cfg_reset_ticks = kpdc_pkg::RESET_HOLD_TICKS_RESET;
         cfg_click_en    = 1'b0;
         cfg_pair_en     = 1'b0;
         cfg_reset_en    = 1'b0;
         press_phase     = PH_IDLE;
         last_key_low    = 1'b0;
         wait_ticks      = '0;
         held_ticks      = '0;
         expected_events.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("event word %0d with nothing expected",
                                         rsp_ch.key_event));
            end else begin
               want = expected_events.pop_front();
               event_tally[want]++;
               if (rsp_ch.key_event !== want) begin
                  report_mismatch($sformatf("key_event %0d, expected %s",
                                            rsp_ch.key_event, want.name()));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_events.push_back(predict_key_event(req_ch.key_low));
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               kpdc_pkg::CSR_DEBOUNCE_TICKS:   cfg_debounce    = csr_ch.data;
               kpdc_pkg::CSR_PAIR_HOLD_TICKS:  cfg_pair_ticks  = csr_ch.data;
               kpdc_pkg::CSR_RESET_HOLD_TICKS: cfg_reset_ticks = csr_ch.data;
               kpdc_pkg::CSR_CLICK_ENABLE:     cfg_click_en    = csr_ch.data[0];
               kpdc_pkg::CSR_PAIR_ENABLE:      cfg_pair_en     = csr_ch.data[0];
               kpdc_pkg::CSR_RESET_ENABLE:     cfg_reset_en    = csr_ch.data[0];
               default: ;
            endcase
         end
      end
   end

   // Sends one sample word. Called at a falling edge and returns at the
   // falling edge after acceptance with valid still high, so that back to back
   // words need no gap.
   task automatic send_sample(input logic key_low);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.key_low <= key_low;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      samples_sent++;
      @(negedge clock);
   endtask

   // A well formed press: released ticks, then pressed ticks, then a release.
   task automatic press_key(input int lead_ticks, input int low_ticks);
      repeat (lead_ticks) send_sample(1'b0);
      repeat (low_ticks) send_sample(1'b1);
      send_sample(1'b0);
   endtask

   // Releases the key until the tracker is idle, stops sending and waits for
   // every event word to come back.
   task automatic settle_key();
      while (press_phase != PH_IDLE) send_sample(1'b0);
      req_ch.valid <= 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input logic [kpdc_pkg::CSR_IDX_W-1:0] index,
                                 input logic [kpdc_pkg::CSR_DAT_W-1:0] data);
      settle_key();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [kpdc_pkg::TICK_W-1:0] debounce,
                                 input logic [kpdc_pkg::TICK_W-1:0] pair_ticks,
                                 input logic [kpdc_pkg::TICK_W-1:0] reset_ticks,
                                 input logic click_en,
                                 input logic pair_en,
                                 input logic reset_en);
      write_register(kpdc_pkg::CSR_DEBOUNCE_TICKS, debounce);
      write_register(kpdc_pkg::CSR_PAIR_HOLD_TICKS, pair_ticks);
      write_register(kpdc_pkg::CSR_RESET_HOLD_TICKS, reset_ticks);
      write_register(kpdc_pkg::CSR_CLICK_ENABLE,
                     {{(kpdc_pkg::CSR_DAT_W-1){1'b0}}, click_en});
      write_register(kpdc_pkg::CSR_PAIR_ENABLE,
                     {{(kpdc_pkg::CSR_DAT_W-1){1'b0}}, pair_en});
      write_register(kpdc_pkg::CSR_RESET_ENABLE,
                     {{(kpdc_pkg::CSR_DAT_W-1){1'b0}}, reset_en});
   endtask

   // Tick setting for random phases: mostly small, now and then zero.
   function automatic logic [kpdc_pkg::TICK_W-1:0] random_ticks(input int upper);
      if ($urandom_range(9) == 0) begin
         return '0;
      end
      return kpdc_pkg::TICK_W'($urandom_range(1, upper));
   endfunction

   // Register values after reset: all handlers are off, so a press reports
   // nothing. Then only the enables are set, and short presses report clicks,
   // which shows that the default hold thresholds are well above them.
   task automatic test_reset_defaults();
      press_key(1, 3 + 4);
      write_register(kpdc_pkg::CSR_CLICK_ENABLE, 10'd1);
      write_register(kpdc_pkg::CSR_PAIR_ENABLE, 10'd1);
      write_register(kpdc_pkg::CSR_RESET_ENABLE, 10'd1);
      press_key(1, 3 + 1);
      press_key(0, 3 + 20);
   endtask

   // Each class at its threshold, a press dropped by the debounce check, an
   // edge inside the wait, and the fall through of disabled classes.
   task automatic test_classes_and_fallthrough();
      apply_settings(10'd2, 10'd3, 10'd5, 1'b1, 1'b1, 1'b1);
      press_key(1, 2 + 2);
      press_key(0, 2 + 3);
      press_key(1, 2 + 5);
      // Released again by the end of the wait: the press is dropped.
      press_key(1, 2);
      // Bounce inside the wait; the key is down at the check, so it counts.
      send_sample(1'b1);
      send_sample(1'b0);
      press_key(0, 3);
      write_register(kpdc_pkg::CSR_RESET_ENABLE, 10'd0);
      press_key(1, 2 + 6);
      write_register(kpdc_pkg::CSR_PAIR_ENABLE, 10'd0);
      press_key(1, 2 + 6);
      write_register(kpdc_pkg::CSR_CLICK_ENABLE, 10'd0);
      press_key(1, 2 + 6);
   endtask

   // Zero debounce and zero thresholds, writes to unused indexes, and enable
   // writes whose data has bit 0 clear but every other bit set.
   task automatic test_zero_and_masked_writes();
      apply_settings(10'd0, 10'd0, 10'd0, 1'b1, 1'b1, 1'b1);
      press_key(1, 1);
      press_key(1, 2);
      write_register(CSR_SPARE_LO, 10'h3FF);
      write_register(CSR_SPARE_HI, 10'h3FF);
      press_key(0, 2);
      write_register(kpdc_pkg::CSR_RESET_ENABLE, 10'h3FE);
      press_key(1, 2);
      write_register(kpdc_pkg::CSR_PAIR_ENABLE, 10'h3FE);
      press_key(1, 3);
      write_register(kpdc_pkg::CSR_CLICK_ENABLE, 10'h3FE);
      press_key(1, 2);
   endtask

   // Largest thresholds with a short debounce; the hold runs past the top of
   // the held counter, which must stop there and still meet the reset threshold.
   task automatic test_long_press_saturation();
      apply_settings(10'd1, 10'h3FF, 10'h3FF, 1'b1, 1'b1, 1'b1);
      press_key(2, 1 + 1030);
   endtask

   // Random phases: each writes every register, then sends presses of random
   // length around the thresholds, with some chatter and raw noise mixed in.
   // One phase runs without any idling on either side.
   task automatic test_random_presses();
      int phase_idx;
      int stop_at;
      int mode;
      int wait_len;
      int span;
      for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
         apply_settings(phase_idx == 0 ? 10'd1 : random_ticks(6),
                        random_ticks(12), random_ticks(24),
                        phase_idx == 0 ? 1'b1 : 1'($urandom_range(1)),
                        phase_idx == 0 ? 1'b1 : 1'($urandom_range(1)),
                        phase_idx == 0 ? 1'b1 : 1'($urandom_range(1)));
         steady_flow = (phase_idx == 2);
         wait_len = (cfg_debounce == 0) ? 1 : int'(cfg_debounce);
         span = (cfg_pair_ticks > cfg_reset_ticks) ? int'(cfg_pair_ticks)
                                                   : int'(cfg_reset_ticks);
         stop_at = samples_sent + 45;
         while (samples_sent < stop_at) begin
            mode = $urandom_range(9);
            if (mode == 0) begin
               repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(1)));
            end else if (mode == 1) begin
               // Contact chatter: short presses, some ending inside the wait.
               repeat ($urandom_range(1, 3)) begin
                  repeat ($urandom_range(1, wait_len)) send_sample(1'b1);
                  send_sample(1'b0);
               end
            end else begin
               press_key($urandom_range(0, 3), wait_len + $urandom_range(0, span + 2));
            end
         end
         steady_flow = 1'b0;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.key_low = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = kpdc_pkg::CSR_DEBOUNCE_TICKS;
      csr_ch.data    = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_classes_and_fallthrough();
      test_zero_and_masked_writes();
      test_long_press_saturation();
      test_random_presses();
      settle_key();

      $display("Sent %0d key samples and %0d register writes over several settings.",
               samples_sent, csr_writes);
      $display("Events checked: %0d none, %0d click, %0d pair hold, %0d reset hold.",
               event_tally[kpdc_pkg::EV_NONE], event_tally[kpdc_pkg::EV_CLICK],
               event_tally[kpdc_pkg::EV_PAIR], event_tally[kpdc_pkg::EV_RESET]);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
